// File: sv/evhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package evhp_pkg;

   localparam int MAX_VLAN_TAGS  = 2;
   localparam int ETH_HDR_LEN    = 14;
   localparam int TAG_LEN        = 4;
   localparam int OFFSET_SAT     = ETH_HDR_LEN + TAG_LEN * MAX_VLAN_TAGS;
   localparam int OFFSET_WIDTH   = 5;
   localparam int TAG_CNT_WIDTH  = 2;
   localparam int VID_WIDTH      = 12;
   localparam int TYPE_WIDTH     = 16;
   localparam int HDR_LEN_WIDTH  = 5;

   localparam logic [TYPE_WIDTH-1:0] TPID_CTAG = 16'h8100;
   localparam logic [TYPE_WIDTH-1:0] TPID_STAG = 16'h88a8;

   localparam logic [TAG_CNT_WIDTH-1:0] DEPTH_LIMIT_RESET = 2'd2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_VLAN_DEPTH_LIMIT = 1'b0;

   localparam logic [1:0] TAG_POS_TCI_HI  = 2'd0;
   localparam logic [1:0] TAG_POS_TCI_LO  = 2'd1;
   localparam logic [1:0] TAG_POS_TYPE_HI = 2'd2;
   localparam logic [1:0] TAG_POS_TYPE_LO = 2'd3;

   localparam logic STATUS_PARSED = 1'b0;
   localparam logic STATUS_SHORT  = 1'b1;

   typedef struct packed {
      logic                     status;
      logic [TYPE_WIDTH-1:0]    ethertype;
      logic [TAG_CNT_WIDTH-1:0] vlan_count;
      logic [VID_WIDTH-1:0]     outer_vlan_id;
      logic [VID_WIDTH-1:0]     inner_vlan_id;
      logic [HDR_LEN_WIDTH-1:0] header_length;
   } evhp_result_type;

endpackage

`default_nettype wire

// File: sv/evhp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface evhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface evhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [15:0] ethertype;
   logic [1:0]  vlan_count;
   logic [11:0] outer_vlan_id;
   logic [11:0] inner_vlan_id;
   logic [4:0]  header_length;

   modport source (output valid, output status, output ethertype, output vlan_count,
                   output outer_vlan_id, output inner_vlan_id, output header_length,
                   input ready);
   modport sink (input valid, input status, input ethertype, input vlan_count,
                 input outer_vlan_id, input inner_vlan_id, input header_length,
                 output ready);
endinterface

`default_nettype wire

// File: sv/ethernet_vlan_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses the Ethernet header of a frame that arrives one byte per beat, skipping up to two
// 802.1Q or 802.1ad tags (limited by the vlan_depth_limit register at byte address 0), and
// delivers one result beat per frame after its last byte. A byte is taken every cycle; the
// result sits in the output register from the cycle after the last byte is taken, and
// input only stalls while that register holds a result that the sink has not yet taken.
module ethernet_vlan_header_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   evhp_req_if.sink                                 req_bus,
   evhp_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [evhp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [evhp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output      logic [evhp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output      logic                                csr_pready
);
   import evhp_pkg::*;

   logic [TAG_CNT_WIDTH-1:0] depth_limit_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   evhp_result_type          rsp_ff;
   evhp_result_type          result;
   logic                     take;
   logic                     csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit = csr_paddr[2] == REG_VLAN_DEPTH_LIMIT;
   assign csr_prdata = csr_hit ?
                       {{(CSR_DATA_WIDTH - TAG_CNT_WIDTH){1'b0}}, depth_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= DEPTH_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         depth_limit_ff <= csr_pwdata[TAG_CNT_WIDTH-1:0];
      end
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign take = req_bus.valid && req_bus.ready;

   evhp_tag_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_bus.data_byte),
      .last_byte   (req_bus.last_byte),
      .depth_limit (depth_limit_ff),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && req_bus.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_bus.last_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = rsp_ff.status;
   assign rsp_bus.ethertype = rsp_ff.ethertype;
   assign rsp_bus.vlan_count = rsp_ff.vlan_count;
   assign rsp_bus.outer_vlan_id = rsp_ff.outer_vlan_id;
   assign rsp_bus.inner_vlan_id = rsp_ff.inner_vlan_id;
   assign rsp_bus.header_length = rsp_ff.header_length;

endmodule

`default_nettype wire

// File: sv/evhp_tag_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module evhp_tag_walker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              take,
   input  wire logic [7:0]                        data_byte,
   input  wire logic                              last_byte,
   input  wire logic [evhp_pkg::TAG_CNT_WIDTH-1:0] depth_limit,
   output evhp_pkg::evhp_result_type              result
);
   import evhp_pkg::*;

   logic [OFFSET_WIDTH-1:0]  offset_ff, offset_in;
   logic [7:0]               held_ff, held_in;
   logic [TYPE_WIDTH-1:0]    type_ff, type_in;
   logic [TAG_CNT_WIDTH-1:0] tags_ff, tags_in;
   logic [VID_WIDTH-1:0]     vid0_ff, vid0_in;
   logic [VID_WIDTH-1:0]     vid1_ff, vid1_in;

   logic [TAG_CNT_WIDTH-1:0] limit;
   logic [OFFSET_WIDTH-1:0]  rel;
   logic [2:0]               tag_idx;
   logic [1:0]               tag_pos;
   logic                     in_tag;
   logic                     take_tag;
   logic                     type_is_vlan;
   logic                     short_frame;

   always_comb begin
      limit = (depth_limit > TAG_CNT_WIDTH'(MAX_VLAN_TAGS)) ?
              TAG_CNT_WIDTH'(MAX_VLAN_TAGS) : depth_limit;
      rel = offset_ff - OFFSET_WIDTH'(ETH_HDR_LEN);
      tag_idx = rel[4:2];
      tag_pos = rel[1:0];
      in_tag = (offset_ff >= OFFSET_WIDTH'(ETH_HDR_LEN)) &&
               (offset_ff < OFFSET_WIDTH'(OFFSET_SAT));
      type_is_vlan = (type_ff == TPID_CTAG) || (type_ff == TPID_STAG);
      take_tag = in_tag && (tag_idx < {1'b0, limit}) && (tag_idx == {1'b0, tags_ff}) &&
                 type_is_vlan;

      held_in = held_ff;
      type_in = type_ff;
      tags_in = tags_ff;
      vid0_in = vid0_ff;
      vid1_in = vid1_ff;

      if (offset_ff == OFFSET_WIDTH'(ETH_HDR_LEN - 2)) begin
         held_in = data_byte;
      end else if (offset_ff == OFFSET_WIDTH'(ETH_HDR_LEN - 1)) begin
         type_in = {held_ff, data_byte};
      end else if (take_tag) begin
         case (tag_pos)
            TAG_POS_TCI_HI, TAG_POS_TYPE_HI: begin
               held_in = data_byte;
            end
            TAG_POS_TCI_LO: begin
               if (tag_idx[0]) begin
                  vid1_in = {held_ff[3:0], data_byte};
               end else begin
                  vid0_in = {held_ff[3:0], data_byte};
               end
            end
            TAG_POS_TYPE_LO: begin
               type_in = {held_ff, data_byte};
               tags_in = tags_ff + 1'b1;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end

      offset_in = (offset_ff < OFFSET_WIDTH'(OFFSET_SAT)) ? offset_ff + 1'b1 : offset_ff;

      short_frame = offset_ff < OFFSET_WIDTH'(ETH_HDR_LEN - 1);
      if (short_frame) begin
         result = '0;
         result.status = STATUS_SHORT;
      end else begin
         result.status = STATUS_PARSED;
         result.ethertype = type_in;
         result.vlan_count = tags_in;
         result.outer_vlan_id = (tags_in >= 2'd1) ? vid0_in : '0;
         result.inner_vlan_id = (tags_in >= 2'd2) ? vid1_in : '0;
         result.header_length = HDR_LEN_WIDTH'(ETH_HDR_LEN) + {1'b0, tags_in, 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         offset_ff <= '0;
         held_ff <= '0;
         type_ff <= '0;
         tags_ff <= '0;
         vid0_ff <= '0;
         vid1_ff <= '0;
      end else if (take) begin
         offset_ff <= offset_in;
         held_ff <= held_in;
         type_ff <= type_in;
         tags_ff <= tags_in;
         vid0_ff <= vid0_in;
         vid1_ff <= vid1_in;
      end
   end

endmodule

`default_nettype wire
